>>> rtl/core/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and constants of the fixed partition allocator: field widths,
// policy, status and register codes, and the scan record control bits.
// ----------------------------------------------------------------------------
package fpa_pkg;

   // Default sizing of the partition table.
   localparam int DefaultNumParts = 8;
   localparam int DefaultSizeWidth = 16;

   // Fixed widths of the port fields.
   localparam int ModeW = 1;
   localparam int PartIndexW = 3;
   localparam int AmountW = 16;
   localparam int StatusW = 2;
   localparam int LeftOverW = 16;
   localparam int ReqNumW = 8;
   localparam int PolicyW = 2;
   localparam int PartsInUseW = 4;
   localparam int CsrIndexW = 2;
   localparam int CsrDataW = 4;

   // Transaction kinds.
   localparam logic [ModeW-1:0] MODE_LOAD = 1'b0;
   localparam logic [ModeW-1:0] MODE_REQUEST = 1'b1;

   // Placement policies; the unused code behaves as first fit.
   localparam logic [PolicyW-1:0] POL_FIRST = 2'd0;
   localparam logic [PolicyW-1:0] POL_BEST = 2'd1;
   localparam logic [PolicyW-1:0] POL_WORST = 2'd2;

   // Result status codes.
   localparam logic [StatusW-1:0] STAT_LOADED = 2'd0;
   localparam logic [StatusW-1:0] STAT_ALLOCATED = 2'd1;
   localparam logic [StatusW-1:0] STAT_NOT_ALLOCATED = 2'd2;

   // Configuration register indexes and the parts-in-use reset value.
   localparam logic [CsrIndexW-1:0] REG_POLICY = 2'd0;
   localparam logic [CsrIndexW-1:0] REG_PARTS_IN_USE = 2'd1;
   localparam logic [PartsInUseW-1:0] PARTS_IN_USE_RESET = 4'd8;

   // Control bits of the scan record that travels along the cell row.
   typedef struct packed {
      logic valid;
      logic found;
   } scan_ctl_type;

endpackage

>>> rtl/core/fpa_cell.sv
// ----------------------------------------------------------------------------
// fpa_cell
// One partition of the allocator. Holds that partition's free size, folds
// itself into the passing scan record and hands the record to its neighbour.
// ----------------------------------------------------------------------------
module fpa_cell #(
   parameter int NUM_PARTS = fpa_pkg::DefaultNumParts,
   parameter int SIZE_WIDTH = fpa_pkg::DefaultSizeWidth,
   parameter int CELL_IDX = 0,
   localparam int PW = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1
) (
   input  logic                             clock,
   input  logic                             reset,
   // Broadcast scan parameters.
   input  logic [fpa_pkg::PolicyW-1:0]      policy,
   input  logic [fpa_pkg::PartsInUseW-1:0]  parts_in_use,
   input  logic [SIZE_WIDTH-1:0]            amount,
   // Write-back of the free size.
   input  logic                             wr_en,
   input  logic [SIZE_WIDTH-1:0]            wr_data,
   // Scan record from the left neighbour.
   input  fpa_pkg::scan_ctl_type            ctl_in,
   input  logic [PW-1:0]                    pick_in,
   input  logic [SIZE_WIDTH-1:0]            value_in,
   // Scan record to the right neighbour.
   output fpa_pkg::scan_ctl_type            ctl_out,
   output logic [PW-1:0]                    pick_out,
   output logic [SIZE_WIDTH-1:0]            value_out
);
   import fpa_pkg::*;

   localparam int CW = ((PW > PartsInUseW) ? PW : PartsInUseW) + 1;

   logic [SIZE_WIDTH-1:0] free_ff, free_in;
   scan_ctl_type          ctl_ff, ctl_in_nxt;
   logic [PW-1:0]         pick_ff, pick_in_nxt;
   logic [SIZE_WIDTH-1:0] value_ff, value_in_nxt;
   logic                  active, fits, take;

   // The cell takes part only while its index lies below the partitions in use.
   assign active = CW'(parts_in_use) > CW'(CELL_IDX);
   assign fits = active && (free_ff >= amount);

   // A fitting cell replaces the candidate when none was found yet, or when it
   // is strictly better under the best or worst fit policy.
   always_comb begin
      take = 1'b0;
      if (fits) begin
         if (!ctl_in.found) begin
            take = 1'b1;
         end else if (policy == POL_BEST) begin
            take = free_ff < value_in;
         end else if (policy == POL_WORST) begin
            take = free_ff > value_in;
         end
      end
   end

   // Next values of the stored size and the outgoing record.
   always_comb begin
      free_in = wr_en ? wr_data : free_ff;
      ctl_in_nxt.valid = ctl_in.valid;
      ctl_in_nxt.found = ctl_in.found | take;
      pick_in_nxt = take ? PW'(CELL_IDX) : pick_in;
      value_in_nxt = take ? free_ff : value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= '0;
         ctl_ff <= '0;
      end else begin
         free_ff <= free_in;
         ctl_ff <= ctl_in_nxt;
      end
      pick_ff <= pick_in_nxt;
      value_ff <= value_in_nxt;
   end

   assign ctl_out = ctl_ff;
   assign pick_out = pick_ff;
   assign value_out = value_ff;

   // A record leaves the cell in the cycle after it came in.
   assert property (@(posedge clock) disable iff (reset)
      ctl_in.valid |=> ctl_out.valid)
      else $error("scan record lost in cell");

   // A found record stays found further down the row.
   assert property (@(posedge clock) disable iff (reset)
      ctl_in.valid && ctl_in.found |=> ctl_out.found)
      else $error("scan candidate dropped in cell");

   // A write-back never coincides with a record passing through.
   assert property (@(posedge clock) disable iff (reset)
      !(wr_en && ctl_in.valid))
      else $error("cell written during scan");

endmodule

>>> rtl/core/fixed_partition_allocator.sv
// ----------------------------------------------------------------------------
// fixed_partition_allocator
// Free-size bookkeeping for fixed memory partitions with first, best and
// worst fit placement, built as a row of partition cells.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A load goes from acceptance
// straight to the finish state. A request's scan record is registered,
// enters the row of partition cells and moves one cell per cycle, each
// cell comparing its free size with the best candidate so far; the row's
// result is registered and the chosen cell is written back in the finish state.
// The input opens again in the same cycle as the result appears. A stalled
// result holds the block in the finish state. Configuration writes are
// accepted in every cycle.
// ----------------------------------------------------------------------------
module fixed_partition_allocator #(
   parameter int NUM_PARTS = fpa_pkg::DefaultNumParts,
   parameter int SIZE_WIDTH = fpa_pkg::DefaultSizeWidth
) (
   input  logic                            clock,
   input  logic                            reset,
   // Configuration port.
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [fpa_pkg::CsrIndexW-1:0]   csr_index,
   input  logic [fpa_pkg::CsrDataW-1:0]    csr_data,
   // Input channel.
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [fpa_pkg::ModeW-1:0]       req_mode,
   input  logic [fpa_pkg::PartIndexW-1:0]  req_part_index,
   input  logic [fpa_pkg::AmountW-1:0]     req_amount,
   // Result channel.
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [fpa_pkg::StatusW-1:0]     rsp_status,
   output logic [fpa_pkg::PartIndexW-1:0]  rsp_chosen_part,
   output logic [fpa_pkg::LeftOverW-1:0]   rsp_left_over,
   output logic [fpa_pkg::ReqNumW-1:0]     rsp_request_number
);
   import fpa_pkg::*;

   localparam int PW = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
   localparam int XW = PW + PartIndexW;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // Control and payload registers.
   state_type             state_ff, state_in;
   logic                  is_req_ff, is_req_in;
   logic [PartIndexW-1:0] idx_ff, idx_in;
   logic [SIZE_WIDTH-1:0] amt_ff, amt_in;
   logic [PolicyW-1:0]    policy_ff, policy_in;
   logic [PartsInUseW-1:0] piu_ff, piu_in;
   logic [ReqNumW-1:0]    count_ff, count_in;
   logic                  found_ff, found_in;
   logic [PW-1:0]         pick_ff, pick_in;
   logic [SIZE_WIDTH-1:0] pickval_ff, pickval_in;
   logic                  launch_ff, launch_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [StatusW-1:0]    rsp_status_ff, rsp_status_in;
   logic [PartIndexW-1:0] rsp_chosen_ff, rsp_chosen_in;
   logic [LeftOverW-1:0]  rsp_left_ff, rsp_left_in;
   logic [ReqNumW-1:0]    rsp_reqnum_ff, rsp_reqnum_in;

   // Cell row wiring and helpers.
   scan_ctl_type          chain_ctl [NUM_PARTS+1];
   logic [PW-1:0]         chain_pick [NUM_PARTS+1];
   logic [SIZE_WIDTH-1:0] chain_value [NUM_PARTS+1];
   logic [NUM_PARTS-1:0]  cell_wr_en;
   logic [SIZE_WIDTH-1:0] cell_wr_data;
   logic                  req_fire, csr_fire, finish_go;
   logic [SIZE_WIDTH+AmountW-1:0] amt_ext;
   logic [XW-1:0]         idx_ext, pick_ext;
   logic [SIZE_WIDTH+LeftOverW-1:0] left_ext;
   logic                  idx_in_range;
   logic [SIZE_WIDTH-1:0] new_free;

   assign req_fire = req_valid && !req_stall;
   assign csr_fire = csr_valid && csr_ready;
   assign csr_ready = 1'b1;
   assign req_stall = state_ff != ST_IDLE;
   assign finish_go = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   // Width adaptation between the port fields and the partition size.
   assign amt_ext = {{SIZE_WIDTH{1'b0}}, req_amount};
   assign idx_ext = {{PW{1'b0}}, idx_ff};
   assign pick_ext = {{PartIndexW{1'b0}}, pick_ff};
   assign idx_in_range = idx_ext < XW'(NUM_PARTS);
   assign new_free = pickval_ff - amt_ff;

   // Scan record entering the first cell.
   assign chain_ctl[0] = '{valid: launch_ff, found: 1'b0};
   assign chain_pick[0] = '0;
   assign chain_value[0] = '0;
   assign cell_wr_data = is_req_ff ? new_free : amt_ff;

   // Row of partition cells.
   for (genvar k = 0; k < NUM_PARTS; k++) begin : g_cell
      assign cell_wr_en[k] = finish_go &&
         (is_req_ff ? (found_ff && (pick_ff == PW'(k))) : (idx_ext == XW'(k)));

      fpa_cell #(
         .NUM_PARTS  (NUM_PARTS),
         .SIZE_WIDTH (SIZE_WIDTH),
         .CELL_IDX   (k)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .policy       (policy_ff),
         .parts_in_use (piu_ff),
         .amount       (amt_ff),
         .wr_en        (cell_wr_en[k]),
         .wr_data      (cell_wr_data),
         .ctl_in       (chain_ctl[k]),
         .pick_in      (chain_pick[k]),
         .value_in     (chain_value[k]),
         .ctl_out      (chain_ctl[k+1]),
         .pick_out     (chain_pick[k+1]),
         .value_out    (chain_value[k+1])
      );
   end

   // Sequencer: next values of configuration registers, state, scan result, counter and result slot.
   always_comb begin
      state_in = state_ff;
      is_req_in = is_req_ff;
      idx_in = idx_ff;
      amt_in = amt_ff;
      policy_in = policy_ff;
      piu_in = piu_ff;
      count_in = count_ff;
      found_in = found_ff;
      pick_in = pick_ff;
      pickval_in = pickval_ff;
      launch_in = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_chosen_in = rsp_chosen_ff;
      rsp_left_in = rsp_left_ff;
      rsp_reqnum_in = rsp_reqnum_ff;
      left_ext = '0;

      // Configuration writes.
      if (csr_fire) begin
         unique case (csr_index)
            REG_POLICY:       policy_in = csr_data[PolicyW-1:0];
            REG_PARTS_IN_USE: piu_in = csr_data[PartsInUseW-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               is_req_in = req_mode == MODE_REQUEST;
               idx_in = req_part_index;
               amt_in = amt_ext[SIZE_WIDTH-1:0];
               if (req_mode == MODE_REQUEST) begin
                  launch_in = 1'b1;
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SCAN: begin
            if (chain_ctl[NUM_PARTS].valid) begin
               found_in = chain_ctl[NUM_PARTS].found;
               pick_in = chain_pick[NUM_PARTS];
               pickval_in = chain_value[NUM_PARTS];
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (finish_go) begin
               rsp_valid_in = 1'b1;
               rsp_reqnum_in = count_ff;
               if (!is_req_ff) begin
                  rsp_status_in = STAT_LOADED;
                  rsp_chosen_in = idx_ff;
                  left_ext = {{LeftOverW{1'b0}}, (idx_in_range ? amt_ff : '0)};
               end else begin
                  count_in = count_ff + 1'b1;
                  if (found_ff) begin
                     rsp_status_in = STAT_ALLOCATED;
                     rsp_chosen_in = pick_ext[PartIndexW-1:0];
                     left_ext = {{LeftOverW{1'b0}}, new_free};
                  end else begin
                     rsp_status_in = STAT_NOT_ALLOCATED;
                     rsp_chosen_in = '0;
                  end
               end
               rsp_left_in = left_ext[LeftOverW-1:0];
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         policy_ff <= POL_FIRST;
         piu_ff <= PARTS_IN_USE_RESET;
         count_ff <= '0;
         launch_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         policy_ff <= policy_in;
         piu_ff <= piu_in;
         count_ff <= count_in;
         launch_ff <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      is_req_ff <= is_req_in;
      idx_ff <= idx_in;
      amt_ff <= amt_in;
      found_ff <= found_in;
      pick_ff <= pick_in;
      pickval_ff <= pickval_in;
      rsp_status_ff <= rsp_status_in;
      rsp_chosen_ff <= rsp_chosen_in;
      rsp_left_ff <= rsp_left_in;
      rsp_reqnum_ff <= rsp_reqnum_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_chosen_part = rsp_chosen_ff;
   assign rsp_left_over = rsp_left_ff;
   assign rsp_request_number = rsp_reqnum_ff;

   // An accepted transaction closes the input until its result is produced.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> req_stall)
      else $error("input accepted while a transaction is in progress");

   // The scan record only leaves the row while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      chain_ctl[NUM_PARTS].valid |-> state_ff == ST_SCAN)
      else $error("scan record arrived outside the scan phase");

   // A refused request reports neither a partition nor a remaining size.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_NOT_ALLOCATED |->
         rsp_chosen_part == '0 && rsp_left_over == '0)
      else $error("refused request carries a partition");

   // The request counter moves only when a request result is produced.
   assert property (@(posedge clock) disable iff (reset)
      count_ff != $past(count_ff) |-> $past(finish_go) && $past(is_req_ff))
      else $error("request counter moved without a request");

endmodule

>>> verif/tb_fixed_partition_allocator.sv
// ----------------------------------------------------------------------------
// tb_fixed_partition_allocator
// Self-checking bench for the fixed partition allocator. A directed table
// covers reset state, field extremes, every placement policy, ties, the
// unused policy code and out-of-range partition counts. Long random phases
// with fresh register settings follow. Results are compared with an in-bench
// predictor or a typed row's result, and both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fixed_partition_allocator;
   import fpa_pkg::*;

   localparam int NumParts = DefaultNumParts;
   localparam int SettleCycles = NumParts + 8;
   localparam int LongHoldCycles = 300;
   localparam int RandomPhases = 12;
   localparam int ItemsPerPhase = 80;
   localparam int HoldPhase = 4;
   localparam int HoldBurst = 16;
   // Register index that selects no register; writes to it change nothing.
   localparam logic [CsrIndexW-1:0] REG_SPARE = 2'd2;

   typedef struct packed {
      logic [StatusW-1:0]    status;
      logic [PartIndexW-1:0] part;
      logic [LeftOverW-1:0]  left;
      logic [ReqNumW-1:0]    reqno;
   } placement_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [CsrIndexW-1:0]   reg_index;
      logic [CsrDataW-1:0]    reg_data;
      logic [ModeW-1:0]       mode;
      logic [PartIndexW-1:0]  idx;
      logic [AmountW-1:0]     amt;
      logic                   typed;
      placement_type          want;
   } stim_row_type;

   localparam placement_type NO_TYPED = '0;

   // Directed table; a row with typed set carries its result written out.
   localparam int DirectedRows = 35;
   stim_row_type directed_rows [DirectedRows] = '{
      '{ROW_ITEM, REG_POLICY, 4'd0, MODE_REQUEST, 3'd0, 16'd0, 1'b1,
        '{STAT_ALLOCATED, 3'd0, 16'd0, 8'd0}},
      '{ROW_ITEM, REG_POLICY, 4'd0, MODE_REQUEST, 3'd0, 16'd1, 1'b1,
        '{STAT_NOT_ALLOCATED, 3'd0, 16'd0, 8'd1}},
      '{ROW_ITEM, REG_POLICY, 4'd0, MODE_LOAD, 3'd0, 16'hFFFF, 1'b1,
        '{STAT_LOADED, 3'd0, 16'hFFFF, 8'd2}},
      '{ROW_ITEM, REG_POLICY, 4'd0, MODE_LOAD, 3'd7, 16'h8000, 1'b1,
        '{STAT_LOADED, 3'd7, 16'h8000, 8'd2}},
      '{ROW_ITEM, REG_POLICY, 4'd0, MODE_REQUEST, 3'd5, 16'hFFFF, 1'b1,
        '{STAT_ALLOCATED, 3'd0, 16'd0, 8'd2}},
      '{ROW_ITEM, REG_POLICY, 4'd0, MODE_LOAD, 3'd0, 16'hAAAA, 1'b0, NO_TYPED},
      '{ROW_ITEM, REG_POLICY, 4'd0, MODE_LOAD, 3'd1, 16'h5555, 1'b0, NO_TYPED},
      '{ROW_ITEM, REG_POLICY, 4'd0, MODE_LOAD, 3'd3, 16'd100, 1'b0, NO_TYPED},
      '{ROW_ITEM, REG_POLICY, 4'd0, MODE_LOAD, 3'd5, 16'd300, 1'b0, NO_TYPED},
      '{ROW_ITEM, REG_POLICY, 4'd0, MODE_LOAD, 3'd2, 16'd200, 1'b0, NO_TYPED},
      '{ROW_ITEM, REG_POLICY, 4'd0, MODE_REQUEST, 3'd7, 16'd150, 1'b0, NO_TYPED},
      '{ROW_CSR, REG_POLICY, 4'd1, MODE_LOAD, 3'd0, 16'd0, 1'b0, NO_TYPED},
      '{ROW_ITEM, REG_POLICY, 4'd0, MODE_REQUEST, 3'd0, 16'd150, 1'b0, NO_TYPED},
      '{ROW_ITEM, REG_POLICY, 4'd0, MODE_REQUEST, 3'd0, 16'd60, 1'b0, NO_TYPED},
      '{ROW_CSR, REG_POLICY, 4'd2, MODE_LOAD, 3'd0, 16'd0, 1'b0, NO_TYPED},
      '{ROW_ITEM, REG_POLICY, 4'd0, MODE_REQUEST, 3'd0, 16'd1000, 1'b0, NO_TYPED},
      '{ROW_ITEM, REG_POLICY, 4'd0, MODE_LOAD, 3'd4, 16'hFFFF, 1'b0, NO_TYPED},
      '{ROW_ITEM, REG_POLICY, 4'd0, MODE_LOAD, 3'd6, 16'hFFFF, 1'b0, NO_TYPED},
      '{ROW_ITEM, REG_POLICY, 4'd0, MODE_REQUEST, 3'd0, 16'd0, 1'b0, NO_TYPED},
      '{ROW_CSR, REG_POLICY, 4'd15, MODE_LOAD, 3'd0, 16'd0, 1'b0, NO_TYPED},
      '{ROW_ITEM, REG_POLICY, 4'd0, MODE_REQUEST, 3'd0, 16'd10, 1'b0, NO_TYPED},
      '{ROW_CSR, REG_PARTS_IN_USE, 4'd0, MODE_LOAD, 3'd0, 16'd0, 1'b0, NO_TYPED},
      '{ROW_ITEM, REG_POLICY, 4'd0, MODE_REQUEST, 3'd0, 16'd0, 1'b1,
        '{STAT_NOT_ALLOCATED, 3'd0, 16'd0, 8'd9}},
      '{ROW_CSR, REG_PARTS_IN_USE, 4'd15, MODE_LOAD, 3'd0, 16'd0, 1'b0, NO_TYPED},
      '{ROW_ITEM, REG_POLICY, 4'd0, MODE_REQUEST, 3'd0, 16'hFFFF, 1'b0, NO_TYPED},
      '{ROW_CSR, REG_PARTS_IN_USE, 4'd1, MODE_LOAD, 3'd0, 16'd0, 1'b0, NO_TYPED},
      '{ROW_ITEM, REG_POLICY, 4'd0, MODE_REQUEST, 3'd0, 16'd5, 1'b0, NO_TYPED},
      '{ROW_CSR, REG_SPARE, 4'd5, MODE_LOAD, 3'd0, 16'd0, 1'b0, NO_TYPED},
      '{ROW_ITEM, REG_POLICY, 4'd0, MODE_LOAD, 3'd6, 16'd0, 1'b0, NO_TYPED},
      '{ROW_CSR, REG_POLICY, 4'd5, MODE_LOAD, 3'd0, 16'd0, 1'b0, NO_TYPED},
      '{ROW_CSR, REG_PARTS_IN_USE, 4'd8, MODE_LOAD, 3'd0, 16'd0, 1'b0, NO_TYPED},
      '{ROW_ITEM, REG_POLICY, 4'd0, MODE_LOAD, 3'd1, 16'd500, 1'b0, NO_TYPED},
      '{ROW_ITEM, REG_POLICY, 4'd0, MODE_LOAD, 3'd3, 16'd500, 1'b0, NO_TYPED},
      '{ROW_ITEM, REG_POLICY, 4'd0, MODE_REQUEST, 3'd0, 16'd400, 1'b0, NO_TYPED},
      '{ROW_CSR, REG_POLICY, 4'd0, MODE_LOAD, 3'd0, 16'd0, 1'b0, NO_TYPED}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CsrIndexW-1:0]   csr_index = REG_POLICY;
   logic [CsrDataW-1:0]    csr_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [ModeW-1:0]       req_mode = MODE_LOAD;
   logic [PartIndexW-1:0]  req_part_index = '0;
   logic [AmountW-1:0]     req_amount = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [StatusW-1:0]     rsp_status;
   logic [PartIndexW-1:0]  rsp_chosen_part;
   logic [LeftOverW-1:0]   rsp_left_over;
   logic [ReqNumW-1:0]     rsp_request_number;

   // Predictor state: free space per partition, request count, registers.
   logic [DefaultSizeWidth-1:0] part_free [NumParts];
   logic [ReqNumW-1:0]          served_count;
   logic [PolicyW-1:0]          cur_policy;
   logic [PartsInUseW-1:0]      cur_parts;

   placement_type predicted_placements [$];
   int            error_count = 0;
   bit            quiet_phase = 1'b0;
   bit            hold_results = 1'b0;

   fixed_partition_allocator i_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_part_index     (req_part_index),
      .req_amount         (req_amount),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_chosen_part    (rsp_chosen_part),
      .rsp_left_over      (rsp_left_over),
      .rsp_request_number (rsp_request_number)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

   // Applies one transaction to the predicted partition table and returns
   // the result the block should give for it.
   function automatic placement_type place_transaction(logic [ModeW-1:0] mode,
                                                       logic [PartIndexW-1:0] idx,
                                                       logic [AmountW-1:0] amt);
      placement_type outcome;
      int            scan;
      int            pick;
      bit            found;
      outcome = '0;
      outcome.reqno = served_count;
      if (mode == MODE_LOAD) begin
         outcome.status = STAT_LOADED;
         outcome.part = idx;
         if (int'(idx) < NumParts) begin
            part_free[idx] = amt;
            outcome.left = amt;
         end
      end else begin
         scan = (int'(cur_parts) > NumParts) ? NumParts : int'(cur_parts);
         found = 1'b0;
         pick = 0;
         for (int j = 0; j < scan; j++) begin
            if (part_free[j] >= amt) begin
               if (!found) begin
                  found = 1'b1;
                  pick = j;
                  if (cur_policy != POL_BEST && cur_policy != POL_WORST) break;
               end else if (cur_policy == POL_BEST && part_free[j] < part_free[pick]) begin
                  pick = j;
               end else if (cur_policy == POL_WORST && part_free[j] > part_free[pick]) begin
                  pick = j;
               end
            end
         end
         if (found) begin
            part_free[pick] = part_free[pick] - amt;
            outcome.status = STAT_ALLOCATED;
            outcome.part = PartIndexW'(pick);
            outcome.left = part_free[pick];
         end else begin
            outcome.status = STAT_NOT_ALLOCATED;
         end
         served_count = served_count + 1'b1;
      end
      return outcome;
   endfunction

   // Holds the input channel idle until every predicted result has arrived
   // and the block has had time to finish any work in flight.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (predicted_placements.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_register(logic [CsrIndexW-1:0] index, logic [CsrDataW-1:0] data);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == REG_POLICY) cur_policy = data[PolicyW-1:0];
      else if (index == REG_PARTS_IN_USE) cur_parts = data;
   endtask

   // Offers one transaction after an idle gap and records its expected
   // result once it is accepted. Valid stays high into the next transaction
   // when that one has no gap.
   task automatic offer_transaction(logic [ModeW-1:0] mode, logic [PartIndexW-1:0] idx,
                                    logic [AmountW-1:0] amt, int gap,
                                    logic typed, placement_type want);
      placement_type outcome;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_part_index <= idx;
      req_amount <= amt;
      do @(posedge clock); while (req_stall);
      outcome = place_transaction(mode, idx, amt);
      predicted_placements.push_back(typed ? want : outcome);
   endtask

   // Stimulus: reset, directed table, then random phases.
   initial begin
      int                     gap;
      int                     pick;
      logic [ModeW-1:0]       mode;
      logic [PartIndexW-1:0]  idx;
      logic [AmountW-1:0]     amt;
      logic [PartsInUseW-1:0] parts;
      foreach (part_free[k]) part_free[k] = '0;
      served_count = '0;
      cur_policy = POL_FIRST;
      cur_parts = PARTS_IN_USE_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_CSR) begin
            write_register(directed_rows[r].reg_index, directed_rows[r].reg_data);
         end else begin
            offer_transaction(directed_rows[r].mode, directed_rows[r].idx,
                              directed_rows[r].amt, $urandom_range(0, 12),
                              directed_rows[r].typed, directed_rows[r].want);
         end
      end

      for (int phase = 0; phase < RandomPhases; phase++) begin
         // New register setting for each phase, extremes included now and then.
         write_register(REG_POLICY, CsrDataW'($urandom_range(0, 15)));
         pick = $urandom_range(0, 9);
         if (pick == 0) parts = '0;
         else if (pick == 1) parts = PartsInUseW'($urandom_range(9, 15));
         else parts = PartsInUseW'($urandom_range(1, NumParts));
         write_register(REG_PARTS_IN_USE, parts);
         quiet_phase = ($urandom_range(0, 3) == 0);
         if (phase == HoldPhase) begin
            // Results are held back for a long stretch while transactions keep coming.
            wait_drained();
            hold_results = 1'b1;
         end
         for (int n = 0; n < ItemsPerPhase; n++) begin
            mode = ($urandom_range(0, 9) < 4) ? MODE_LOAD : MODE_REQUEST;
            idx = PartIndexW'($urandom_range(0, 7));
            pick = $urandom_range(0, 9);
            if (pick == 0) amt = '0;
            else if (pick == 1) amt = '1;
            else if (pick < 7) amt = AmountW'($urandom_range(0, mode == MODE_LOAD ? 3000 : 1200));
            else amt = AmountW'($urandom);
            if (quiet_phase || (phase == HoldPhase && n < HoldBurst)) gap = 0;
            else gap = $urandom_range(0, 12);
            offer_transaction(mode, idx, amt, gap, 1'b0, NO_TYPED);
         end
         quiet_phase = 1'b0;
      end

      wait_drained();
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Result side: random stalls, one long hold when asked, and the checks.
   initial begin
      int            pause;
      placement_type want;
      @(negedge reset);
      forever begin
         if (hold_results) begin
            rsp_stall <= 1'b1;
            repeat (LongHoldCycles) @(posedge clock);
            hold_results = 1'b0;
         end
         pause = quiet_phase ? 0 : $urandom_range(0, 12);
         if (pause > 0) begin
            rsp_stall <= 1'b1;
            repeat (pause) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         if (predicted_placements.size() == 0) begin
            $display("%0t: unexpected result, status %0d part %0d left %0d number %0d",
                     $time, rsp_status, rsp_chosen_part, rsp_left_over, rsp_request_number);
            error_count++;
         end else begin
            want = predicted_placements.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
               error_count++;
            end
            if (rsp_chosen_part !== want.part) begin
               $display("%0t: chosen_part expected %0d actual %0d",
                        $time, want.part, rsp_chosen_part);
               error_count++;
            end
            if (rsp_left_over !== want.left) begin
               $display("%0t: left_over expected %0d actual %0d",
                        $time, want.left, rsp_left_over);
               error_count++;
            end
            if (rsp_request_number !== want.reqno) begin
               $display("%0t: request_number expected %0d actual %0d",
                        $time, want.reqno, rsp_request_number);
               error_count++;
            end
         end
      end
   end

endmodule

>>> sim.f
rtl/core/fpa_pkg.sv
rtl/core/fpa_cell.sv
rtl/core/fixed_partition_allocator.sv
verif/tb_fixed_partition_allocator.sv
